// ===== rtl/core/ust_pkg.sv =====
package ust_pkg;

  localparam int CNT_W      = 11;
  localparam int RAD_W      = 16;
  localparam int IDX_W      = 21;
  localparam int POS_W      = 17;
  localparam int NRM_W      = 16;
  localparam int TEX_W      = 17;
  localparam int QUO_W      = 17;
  localparam int NUM_W      = 28;
  localparam int Z_W        = 31;
  localparam int P_W        = 34;
  localparam int TRIG_W     = 32;
  localparam int PROD_W     = 64;
  localparam int SIN_LAT    = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTORS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STACKS  = 2'd2;

  localparam logic [RAD_W-1:0] RADIUS_RST  = 16'd256;
  localparam logic [CNT_W-1:0] SECTORS_RST = 11'd32;
  localparam logic [CNT_W-1:0] STACKS_RST  = 11'd16;

  localparam logic ACT_VERTEX = 1'b0;
  localparam logic ACT_QUAD   = 1'b1;

  localparam logic [Z_W-1:0] Z_ONE = 31'h4000_0000;

  localparam logic signed [P_W-1:0] K1  = 34'sd1686629713;
  localparam logic signed [P_W-1:0] K3  = -34'sd693598669;
  localparam logic signed [P_W-1:0] K5  = 34'sd85569306;
  localparam logic signed [P_W-1:0] K7  = -34'sd5026995;
  localparam logic signed [P_W-1:0] K9  = 34'sd172272;
  localparam logic signed [P_W-1:0] K11 = -34'sd3864;

  typedef enum logic [1:0] {
    KIND_VERTEX,
    KIND_QUAD,
    KIND_ERROR
  } kind_e;

  typedef struct packed {
    logic [RAD_W-1:0] radius;
    logic [CNT_W-1:0] sectors;
    logic [CNT_W-1:0] stacks;
  } cfg_t;

  typedef struct packed {
    kind_e            kind;
    logic [CNT_W-1:0] stack;
    logic [CNT_W-1:0] sector;
  } entry_t;

  // Divide by 2^sh, round to nearest, ties away from zero.
  function automatic logic signed [PROD_W-1:0] rdiv(input logic signed [PROD_W-1:0] a,
                                                    input int unsigned sh);
    logic [PROD_W-1:0] m;
    m = a[PROD_W-1] ? (~a + 64'd1) : a;
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return a[PROD_W-1] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [NRM_W-1:0] sat16(input logic signed [PROD_W-1:0] v);
    if (v > 64'sd32767) return 16'sh7FFF;
    if (v < -64'sd32768) return 16'sh8000;
    return v[NRM_W-1:0];
  endfunction

  // Horner coefficient added after step s.
  function automatic logic signed [P_W-1:0] sin_coef(input int unsigned s);
    case (s)
      1:       return K9;
      2:       return K7;
      3:       return K5;
      4:       return K3;
      default: return K1;
    endcase
  endfunction

endpackage

// ===== rtl/core/ust_fifo.sv =====
module ust_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ust_pkg::entry_t entry_i,
  input  logic            pop_i,
  output ust_pkg::entry_t head_o,
  output logic            empty_o,
  output logic            full_o
);
  import ust_pkg::*;

  entry_t          mem_q [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_AW:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= entry_i;
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (Q_AW+1)'(Q_DEPTH));

endmodule

// ===== rtl/core/ust_div.sv =====
module ust_div (
  input  logic                      clk_i,
  input  logic [ust_pkg::NUM_W-1:0] num_i,
  input  logic [ust_pkg::CNT_W-1:0] den_i,
  output logic [ust_pkg::QUO_W-1:0] quo_o
);
  import ust_pkg::*;

  localparam int STAGES = QUO_W;

  logic [NUM_W-1:0] rem_q [STAGES];
  logic [QUO_W-1:0] quo_q [STAGES];

  // One quotient bit per stage, most significant first.
  for (genvar l = 0; l < STAGES; l++) begin : g_stage
    logic [NUM_W-1:0] rem_in;
    logic [QUO_W-1:0] quo_in;
    logic [NUM_W-1:0] dsh;

    if (l == 0) begin : g_first
      assign rem_in = num_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[l-1];
      assign quo_in = quo_q[l-1];
    end

    assign dsh = NUM_W'(den_i) << (STAGES - 1 - l);

    always_ff @(posedge clk_i) begin
      if (rem_in >= dsh) begin
        rem_q[l] <= rem_in - dsh;
        quo_q[l] <= quo_in | (QUO_W'(1) << (STAGES - 1 - l));
      end else begin
        rem_q[l] <= rem_in;
        quo_q[l] <= quo_in;
      end
    end
  end

  assign quo_o = quo_q[STAGES-1];

endmodule

// ===== rtl/core/ust_sin.sv =====
module ust_sin (
  input  logic                    clk_i,
  input  logic [ust_pkg::Z_W-1:0] z_i,
  output logic [ust_pkg::Z_W-1:0] sin_o
);
  import ust_pkg::*;

  logic signed [PROD_W-1:0] prod0_q;
  logic [Z_W-1:0]           z0_q, z1_q, z2_q;

  logic signed [PROD_W-1:0] mprod_q [1:5];
  logic [Z_W-1:0]           mz_q    [1:5];
  logic [Z_W-1:0]           mz2_q   [1:5];
  logic signed [P_W-1:0]    rp_q    [1:5];
  logic [Z_W-1:0]           rz_q    [1:5];
  logic [Z_W-1:0]           rz2_q   [1:4];

  logic signed [PROD_W-1:0] prod6_q;
  logic signed [PROD_W-1:0] r6;
  logic [Z_W-1:0]           sin_q;

  always_ff @(posedge clk_i) begin
    prod0_q <= $signed({33'b0, z_i}) * $signed({33'b0, z_i});
    z0_q    <= z_i;
    z2_q    <= Z_W'(rdiv(prod0_q, 30));
    z1_q    <= z0_q;
  end

  // Horner steps: multiply, then round and add the next coefficient.
  for (genvar s = 1; s <= 5; s++) begin : g_step
    logic signed [P_W-1:0] p_in;
    logic [Z_W-1:0]        z_in, z2_in;

    if (s == 1) begin : g_first
      assign p_in  = K11;
      assign z_in  = z1_q;
      assign z2_in = z2_q;
    end else begin : g_next
      assign p_in  = rp_q[s-1];
      assign z_in  = rz_q[s-1];
      assign z2_in = rz2_q[s-1];
    end

    always_ff @(posedge clk_i) begin
      mprod_q[s] <= p_in * $signed({1'b0, z2_in});
      mz_q[s]    <= z_in;
      mz2_q[s]   <= z2_in;
      rp_q[s]    <= sin_coef(s) + P_W'(rdiv(mprod_q[s], 30));
      rz_q[s]    <= mz_q[s];
    end

    if (s < 5) begin : g_carry
      always_ff @(posedge clk_i) begin
        rz2_q[s] <= mz2_q[s];
      end
    end
  end

  assign r6 = rdiv(prod6_q, 30);

  always_ff @(posedge clk_i) begin
    prod6_q <= rp_q[5] * $signed({1'b0, rz_q[5]});
    if (r6 < 0) sin_q <= '0;
    else if (r6 > 64'sd1073741824) sin_q <= Z_ONE;
    else sin_q <= Z_W'(r6);
  end

  assign sin_o = sin_q;

endmodule

// ===== rtl/core/ust_front.sv =====
module ust_front #(
  parameter int unsigned MAX_SECTORS = 1024,
  parameter int unsigned MAX_STACKS  = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ust_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ust_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           start_i,
  input  logic                           action_i,
  input  logic [ust_pkg::CNT_W-1:0]      stack_pos_i,
  input  logic [ust_pkg::CNT_W-1:0]      sector_pos_i,
  input  logic                           full_i,
  output logic                           push_o,
  output ust_pkg::entry_t                entry_o,
  output ust_pkg::cfg_t                  cfg_o
);
  import ust_pkg::*;

  localparam logic [CNT_W+1:0] MAX_S = (CNT_W+2)'(MAX_SECTORS);
  localparam logic [CNT_W+1:0] MAX_T = (CNT_W+2)'(MAX_STACKS);

  logic [RAD_W-1:0] radius_q;
  logic [CNT_W-1:0] sectors_q, stacks_q;
  logic [CNT_W-1:0] sc, st;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= RADIUS_RST;
      sectors_q <= SECTORS_RST;
      stacks_q  <= STACKS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_RADIUS:  radius_q  <= cfg_data_i;
        CFG_SECTORS: sectors_q <= cfg_data_i[CNT_W-1:0];
        CFG_STACKS:  stacks_q  <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the counts to the supported grid.
  assign sc = (sectors_q == '0) ? CNT_W'(1) :
              ({2'b0, sectors_q} > MAX_S) ? MAX_S[CNT_W-1:0] : sectors_q;
  assign st = (stacks_q == '0) ? CNT_W'(1) :
              ({2'b0, stacks_q} > MAX_T) ? MAX_T[CNT_W-1:0] : stacks_q;

  assign cfg_o = '{radius: radius_q, sectors: sc, stacks: st};

  always_comb begin
    entry_o.stack  = stack_pos_i;
    entry_o.sector = sector_pos_i;
    if (action_i == ACT_QUAD) begin
      entry_o.kind = (stack_pos_i >= st || sector_pos_i >= sc) ? KIND_ERROR : KIND_QUAD;
    end else begin
      entry_o.kind = KIND_VERTEX;
      if (stack_pos_i > st) entry_o.stack = st;
      if (sector_pos_i > sc) entry_o.sector = sc;
    end
  end

  assign push_o = start_i && !full_i;

endmodule

// ===== rtl/core/ust_back.sv =====
module ust_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ust_pkg::cfg_t                     cfg_i,
  input  logic                              empty_i,
  input  ust_pkg::entry_t                   head_i,
  output logic                              pop_o,
  output logic                              valid_o,
  output logic signed [ust_pkg::POS_W-1:0]  pos_x_o,
  output logic signed [ust_pkg::POS_W-1:0]  pos_y_o,
  output logic signed [ust_pkg::POS_W-1:0]  pos_z_o,
  output logic signed [ust_pkg::NRM_W-1:0]  norm_x_o,
  output logic signed [ust_pkg::NRM_W-1:0]  norm_y_o,
  output logic signed [ust_pkg::NRM_W-1:0]  norm_z_o,
  output logic [ust_pkg::TEX_W-1:0]         tex_u_o,
  output logic [ust_pkg::TEX_W-1:0]         tex_v_o,
  output logic [ust_pkg::IDX_W-1:0]         vertex_index_o,
  output logic                              last_o,
  output logic                              range_error_o
);
  import ust_pkg::*;

  localparam int DIV_AT = QUO_W;
  localparam int SIN_AT = DIV_AT + SIN_LAT;
  localparam int TAG_N  = SIN_AT + 4;

  typedef struct packed {
    kind_e            kind;
    logic             last;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] stack;
    logic [CNT_W-1:0] sector;
  } iss_t;

  typedef struct packed {
    kind_e            kind;
    logic             last;
    logic [IDX_W-1:0] idx;
    logic [TEX_W-1:0] tu;
    logic [TEX_W-1:0] tv;
  } tag_t;

  iss_t             iss_d, iss_q;
  logic             iss_v_d, iss_v_q;
  logic             seq_act_d, seq_act_q;
  logic [2:0]       k_d, k_q;
  logic [IDX_W-1:0] first_d, first_q;

  logic [CNT_W:0]     sc1;
  logic [2*CNT_W:0]   fprod;
  logic [IDX_W-1:0]   off;

  assign sc1   = {1'b0, cfg_i.sectors} + 1'b1;
  assign fprod = (2*CNT_W+1)'(head_i.stack) * (2*CNT_W+1)'(sc1) +
                 (2*CNT_W+1)'(head_i.sector);

  always_comb begin
    case (k_q) inside
      3'd1, 3'd4: off = IDX_W'(sc1);
      3'd2, 3'd3: off = IDX_W'(1);
      default:    off = IDX_W'(sc1) + IDX_W'(1);
    endcase
  end

  // Issue one slot a cycle: a vertex, an index of a quad, or an error.
  always_comb begin
    iss_v_d      = 1'b0;
    iss_d.kind   = KIND_VERTEX;
    iss_d.last   = 1'b1;
    iss_d.idx    = '0;
    iss_d.stack  = head_i.stack;
    iss_d.sector = head_i.sector;
    seq_act_d    = seq_act_q;
    k_d          = k_q;
    first_d      = first_q;
    pop_o        = 1'b0;
    if (seq_act_q) begin
      iss_v_d    = 1'b1;
      iss_d.kind = KIND_QUAD;
      iss_d.idx  = first_q + off;
      iss_d.last = (k_q == 3'd5);
      k_d        = k_q + 3'd1;
      if (k_q == 3'd5) seq_act_d = 1'b0;
    end else if (!empty_i) begin
      pop_o   = 1'b1;
      iss_v_d = 1'b1;
      unique case (head_i.kind)
        KIND_VERTEX: iss_d.kind = KIND_VERTEX;
        KIND_QUAD: begin
          iss_d.kind = KIND_QUAD;
          iss_d.idx  = fprod[IDX_W-1:0];
          iss_d.last = 1'b0;
          seq_act_d  = 1'b1;
          k_d        = 3'd1;
          first_d    = fprod[IDX_W-1:0];
        end
        default: iss_d.kind = KIND_ERROR;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_v_q   <= 1'b0;
      seq_act_q <= 1'b0;
      k_q       <= '0;
    end else begin
      iss_v_q   <= iss_v_d;
      seq_act_q <= seq_act_d;
      k_q       <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iss_q   <= iss_d;
    first_q <= first_d;
  end

  // Texture coordinates: rounded quotients from two bit-serial pipelines.
  logic [NUM_W-1:0] num_u, num_v;
  logic [QUO_W-1:0] tu_div, tv_div;

  assign num_u = NUM_W'({iss_q.sector, 16'b0}) + NUM_W'(cfg_i.sectors >> 1);
  assign num_v = NUM_W'({iss_q.stack, 16'b0}) + NUM_W'(cfg_i.stacks >> 1);

  ust_div u_div_u (.clk_i(clk_i), .num_i(num_u), .den_i(cfg_i.sectors), .quo_o(tu_div));
  ust_div u_div_v (.clk_i(clk_i), .num_i(num_v), .den_i(cfg_i.stacks), .quo_o(tv_div));

  // Tag line runs beside the arithmetic, one stage per cycle.
  tag_t tag_q   [1:TAG_N];
  logic tag_v_q [1:TAG_N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tag_v_q[1] <= 1'b0;
    else tag_v_q[1] <= iss_v_q;
  end

  always_ff @(posedge clk_i) begin
    tag_q[1] <= '{kind: iss_q.kind, last: iss_q.last, idx: iss_q.idx, tu: '0, tv: '0};
  end

  for (genvar k = 2; k <= TAG_N; k++) begin : g_tag
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) tag_v_q[k] <= 1'b0;
      else tag_v_q[k] <= tag_v_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      if (k == DIV_AT + 1) begin
        tag_q[k] <= '{kind: tag_q[k-1].kind, last: tag_q[k-1].last, idx: tag_q[k-1].idx,
                      tu: tu_div, tv: tv_div};
      end else begin
        tag_q[k] <= tag_q[k-1];
      end
    end
  end

  // Angles as fractions of a full turn.
  logic [TRIG_W-1:0] phi, theta, phi_t, theta_t;
  logic [TEX_W-1:0]  tu_inv, tu_inv_t;
  logic [Z_W-1:0]    phi_s, phi_c, th_s, th_c;

  assign phi    = {tv_div, 15'b0};
  assign tu_inv = 17'h1_0000 - tu_div;
  assign theta  = {tu_inv[15:0], 16'b0};

  ust_sin u_sin_ps (.clk_i(clk_i), .z_i({1'b0, phi[29:0]}), .sin_o(phi_s));
  ust_sin u_sin_pc (.clk_i(clk_i), .z_i(Z_ONE - {1'b0, phi[29:0]}), .sin_o(phi_c));
  ust_sin u_sin_ts (.clk_i(clk_i), .z_i({1'b0, theta[29:0]}), .sin_o(th_s));
  ust_sin u_sin_tc (.clk_i(clk_i), .z_i(Z_ONE - {1'b0, theta[29:0]}), .sin_o(th_c));

  assign phi_t    = {tag_q[SIN_AT].tv, 15'b0};
  assign tu_inv_t = 17'h1_0000 - tag_q[SIN_AT].tu;
  assign theta_t  = {tu_inv_t[15:0], 16'b0};

  logic signed [TRIG_W-1:0] cp_d, sp_d, ct_d, st_d;
  logic signed [TRIG_W-1:0] cp_a_q, sp_a_q, ct_a_q, st_a_q;

  always_comb begin
    case (phi_t[31:30])
      2'd0:    begin cp_d = $signed({1'b0, phi_c});  sp_d = $signed({1'b0, phi_s});  end
      2'd1:    begin cp_d = -$signed({1'b0, phi_s}); sp_d = $signed({1'b0, phi_c});  end
      2'd2:    begin cp_d = -$signed({1'b0, phi_c}); sp_d = -$signed({1'b0, phi_s}); end
      default: begin cp_d = $signed({1'b0, phi_s});  sp_d = -$signed({1'b0, phi_c}); end
    endcase
    case (theta_t[31:30])
      2'd0:    begin ct_d = $signed({1'b0, th_c});  st_d = $signed({1'b0, th_s});  end
      2'd1:    begin ct_d = -$signed({1'b0, th_s}); st_d = $signed({1'b0, th_c});  end
      2'd2:    begin ct_d = -$signed({1'b0, th_c}); st_d = -$signed({1'b0, th_s}); end
      default: begin ct_d = $signed({1'b0, th_s});  st_d = -$signed({1'b0, th_c}); end
    endcase
  end

  logic signed [PROD_W-1:0] prodx_q, prodz_q;
  logic signed [TRIG_W-1:0] cp_b_q, cp_c_q, px_q, pz_q;
  logic signed [PROD_W-1:0] rx_q, ry_q, rz_q;
  logic signed [NRM_W-1:0]  nx_q, ny_q, nz_q;

  always_ff @(posedge clk_i) begin
    cp_a_q  <= cp_d;
    sp_a_q  <= sp_d;
    ct_a_q  <= ct_d;
    st_a_q  <= st_d;
    prodx_q <= ct_a_q * sp_a_q;
    prodz_q <= st_a_q * sp_a_q;
    cp_b_q  <= cp_a_q;
    px_q    <= TRIG_W'(rdiv(prodx_q, 30));
    pz_q    <= TRIG_W'(rdiv(prodz_q, 30));
    cp_c_q  <= cp_b_q;
    rx_q    <= $signed({1'b0, cfg_i.radius}) * px_q;
    ry_q    <= $signed({1'b0, cfg_i.radius}) * cp_c_q;
    rz_q    <= $signed({1'b0, cfg_i.radius}) * pz_q;
    nx_q    <= sat16(rdiv(PROD_W'(px_q), 15));
    ny_q    <= sat16(rdiv(PROD_W'(cp_c_q), 15));
    nz_q    <= sat16(rdiv(PROD_W'(pz_q), 15));
  end

  // Output register: a result shows for exactly one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else valid_o <= tag_v_q[TAG_N];
  end

  always_ff @(posedge clk_i) begin
    vertex_index_o <= tag_q[TAG_N].idx;
    last_o         <= tag_q[TAG_N].last;
    range_error_o  <= (tag_q[TAG_N].kind == KIND_ERROR);
    if (tag_q[TAG_N].kind == KIND_VERTEX) begin
      pos_x_o  <= POS_W'(rdiv(rx_q, 30));
      pos_y_o  <= POS_W'(rdiv(ry_q, 30));
      pos_z_o  <= POS_W'(rdiv(rz_q, 30));
      norm_x_o <= nx_q;
      norm_y_o <= ny_q;
      norm_z_o <= nz_q;
      tex_u_o  <= tag_q[TAG_N].tu;
      tex_v_o  <= tag_q[TAG_N].tv;
    end else begin
      pos_x_o  <= '0;
      pos_y_o  <= '0;
      pos_z_o  <= '0;
      norm_x_o <= '0;
      norm_y_o <= '0;
      norm_z_o <= '0;
      tex_u_o  <= '0;
      tex_v_o  <= '0;
    end
  end

endmodule

// ===== rtl/core/uv_sphere_tessellator_unit.sv =====
// Throughput: one vertex item per cycle while no quad is being issued; a quad item issues six
// indices, set by the index sequencer; an off-grid quad issues a single error slot.
// Reset: config returns to radius 1.0, 32 sectors, 16 stacks; queue and pipeline empty.
// Results cannot be stalled: each shows for one cycle with result_valid_o high.
module uv_sphere_tessellator_unit #(
  parameter int unsigned MAX_SECTORS = 1024,
  parameter int unsigned MAX_STACKS  = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ust_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ust_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              start,
  output logic                              busy,
  input  logic                              action_i,
  input  logic [ust_pkg::CNT_W-1:0]         stack_pos_i,
  input  logic [ust_pkg::CNT_W-1:0]         sector_pos_i,
  output logic                              result_valid_o,
  output logic signed [ust_pkg::POS_W-1:0]  pos_x_o,
  output logic signed [ust_pkg::POS_W-1:0]  pos_y_o,
  output logic signed [ust_pkg::POS_W-1:0]  pos_z_o,
  output logic signed [ust_pkg::NRM_W-1:0]  norm_x_o,
  output logic signed [ust_pkg::NRM_W-1:0]  norm_y_o,
  output logic signed [ust_pkg::NRM_W-1:0]  norm_z_o,
  output logic [ust_pkg::TEX_W-1:0]         tex_u_o,
  output logic [ust_pkg::TEX_W-1:0]         tex_v_o,
  output logic [ust_pkg::IDX_W-1:0]         vertex_index_o,
  output logic                              last_o,
  output logic                              range_error_o
);
  import ust_pkg::*;

  // Front: config registers, clamping of counts and classification of each item.
  // Queue: four items, so the front keeps accepting while the back runs a quad.
  // Back: slot sequencer, divider pipelines, sine pipelines and the scaling stages.

  cfg_t   cfg;
  entry_t entry, head;
  logic   push, pop, empty, full;

  // Hold off new items only while the queue is full.
  assign busy = full;

  ust_front #(
    .MAX_SECTORS(MAX_SECTORS),
    .MAX_STACKS (MAX_STACKS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .start_i     (start),
    .action_i    (action_i),
    .stack_pos_i (stack_pos_i),
    .sector_pos_i(sector_pos_i),
    .full_i      (full),
    .push_o      (push),
    .entry_o     (entry),
    .cfg_o       (cfg)
  );

  ust_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(entry),
    .pop_i  (pop),
    .head_o (head),
    .empty_o(empty),
    .full_o (full)
  );

  ust_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .empty_i       (empty),
    .head_i        (head),
    .pop_o         (pop),
    .valid_o       (result_valid_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .pos_z_o       (pos_z_o),
    .norm_x_o      (norm_x_o),
    .norm_y_o      (norm_y_o),
    .norm_z_o      (norm_z_o),
    .tex_u_o       (tex_u_o),
    .tex_v_o       (tex_v_o),
    .vertex_index_o(vertex_index_o),
    .last_o        (last_o),
    .range_error_o (range_error_o)
  );

endmodule
